@@ rtl/teletext_enhancement_triplet_decoder_top_macros.svh @@
// Assertion macros used by the triplet decoder checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TELETEXT_ENHANCEMENT_TRIPLET_DECODER_TOP_MACROS_SVH
`define TELETEXT_ENHANCEMENT_TRIPLET_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define TTX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("ttx assertion failed");

// next-cycle implication
`define TTX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("ttx assertion failed");

`endif

@@ rtl/ttx_pkg.sv @@
// Shared types, constants and decode functions for the triplet decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package ttx_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_G2     = 3'd1;
	localparam logic [2:0] KIND_AT     = 3'd2;
	localparam logic [2:0] KIND_ACCENT = 3'd3;
	localparam logic [2:0] KIND_G0     = 3'd4;

	localparam logic [5:0] ADDR_ROWGRP   = 6'h28;
	localparam logic [4:0] MODE_ROWADDR  = 5'h04;
	localparam logic [4:0] MODE_G2       = 5'h0f;
	localparam logic [4:0] MODE_AT       = 5'h10;
	localparam logic [4:0] MODE_DIAC_LO  = 5'h11;
	localparam logic [4:0] MODE_DIAC_HI  = 5'h1f;
	localparam logic [4:0] ROW_ZERO_MAP  = 5'd24;

	typedef struct packed {
		logic        ok;
		logic [17:0] data;
	} ham_t;

	// decoded triplet as it sits in the queue
	typedef struct packed {
		logic       packet_start;
		logic       uncorrectable;
		logic [5:0] addr;
		logic [4:0] mode;
		logic [6:0] data;
	} trip_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] row;
		logic [5:0] column;
		logic [6:0] char_index;
		logic [3:0] accent_index;
		logic [5:0] letter_index;
		logic       uncorrectable;
		logic       terminated;
	} res_t;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[7-i] = b[i];
		return r;
	endfunction

	// Hamming 24/18: single error corrected, double error flagged
	function automatic ham_t ham_decode(input logic [23:0] w);
		ham_t       r;
		logic [5:0] test;
		logic [5:0] fidx;
		logic [23:0] wc;
		test = '0;
		for (int i = 0; i < 23; i++)
			if (w[i])
				test ^= 6'(i + 33);
		if (w[23])
			test ^= 6'h20;
		wc = w;
		r.ok = 1'b1;
		fidx = 6'd30 - test;
		if (test[4:0] != 5'h1f) begin
			if (test[5])
				r.ok = 1'b0;
			else
				for (int i = 0; i < 24; i++)
					if (fidx == 6'(i))
						wc[i] = ~wc[i];
		end
		r.data = {wc[22:16], wc[14:8], wc[6:4], wc[2]};
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ttx_front.sv @@
// Front end: bit reversal, Hamming 24/18 decode and field split of a triplet.
// Depends on ttx_pkg.
`default_nettype none

module ttx_front (
	input  wire logic [23:0]   raw,
	input  wire logic          packet_start,
	output ttx_pkg::trip_t     trip
);

	logic [23:0]   word;
	ttx_pkg::ham_t ham;

	assign word = {ttx_pkg::rev8(raw[23:16]), ttx_pkg::rev8(raw[15:8]),
		ttx_pkg::rev8(raw[7:0])};
	assign ham = ttx_pkg::ham_decode(word);

	always_comb begin
		trip.packet_start  = packet_start;
		trip.uncorrectable = ~ham.ok;
		trip.addr          = ham.data[5:0];
		trip.mode          = ham.data[10:6];
		trip.data          = ham.data[17:11];
	end

endmodule

`default_nettype wire

@@ rtl/ttx_queue.sv @@
// Short register queue between the decode front end and the back end.
// Depends on ttx_pkg.
`default_nettype none

module ttx_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  ttx_pkg::trip_t      push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                nonempty,
	output ttx_pkg::trip_t      head
);

	ttx_pkg::trip_t                  mem_q [ttx_pkg::QDEPTH];
	logic [ttx_pkg::QPTR_W-1:0]      wr_q;
	logic [ttx_pkg::QPTR_W-1:0]      rd_q;
	logic [ttx_pkg::QPTR_W:0]        cnt_q;

	assign full     = (cnt_q == (ttx_pkg::QPTR_W+1)'(ttx_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/ttx_back.sv @@
// Back end: row/stop state, replacement classification and output register.
// Depends on ttx_pkg.
`default_nettype none

module ttx_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  ttx_pkg::trip_t      trip,
	output logic                take,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ttx_pkg::res_t       res
);

	logic [4:0]    row_q;
	logic          stop_q;
	logic          out_valid_q;
	ttx_pkg::res_t res_q;

	logic [4:0]    row_eff, row_nxt;
	logic          stop_eff, stop_nxt;
	logic          rowgrp, diac;
	ttx_pkg::res_t res_d;

	assign take      = in_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		// packet start clears state before the triplet is applied
		row_eff  = trip.packet_start ? 5'd0 : row_q;
		stop_eff = trip.packet_start ? 1'b0 : stop_q;
		row_nxt  = row_eff;
		stop_nxt = stop_eff;
		rowgrp   = (trip.addr >= ttx_pkg::ADDR_ROWGRP);
		diac     = (trip.mode >= ttx_pkg::MODE_DIAC_LO) && (trip.mode <= ttx_pkg::MODE_DIAC_HI);
		res_d    = '0;
		if (trip.uncorrectable) begin
			res_d.uncorrectable = 1'b1;
			res_d.terminated    = stop_eff;
		end else if (stop_eff) begin
			res_d.terminated = 1'b1;
		end else if (rowgrp) begin
			if (trip.mode == ttx_pkg::MODE_ROWADDR)
				row_nxt = (trip.addr == ttx_pkg::ADDR_ROWGRP) ? ttx_pkg::ROW_ZERO_MAP
					: 5'(trip.addr - ttx_pkg::ADDR_ROWGRP);
			if (diac) begin
				stop_nxt         = 1'b1;
				res_d.terminated = 1'b1;
			end
		end else if (trip.mode == ttx_pkg::MODE_G2) begin
			if (trip.data > 7'h1f) begin
				res_d.kind       = ttx_pkg::KIND_G2;
				res_d.char_index = trip.data - 7'h20;
			end
		end else if (trip.mode == ttx_pkg::MODE_AT) begin
			if (trip.data == 7'h40)
				res_d.kind = ttx_pkg::KIND_AT;
		end else if (diac) begin
			if (trip.data >= 7'h41 && trip.data <= 7'h5a) begin
				res_d.kind         = ttx_pkg::KIND_ACCENT;
				res_d.accent_index = 4'(trip.mode - ttx_pkg::MODE_DIAC_LO);
				res_d.letter_index = 6'(trip.data - 7'h41);
			end else if (trip.data >= 7'h61 && trip.data <= 7'h7a) begin
				res_d.kind         = ttx_pkg::KIND_ACCENT;
				res_d.accent_index = 4'(trip.mode - ttx_pkg::MODE_DIAC_LO);
				res_d.letter_index = 6'(trip.data - 7'h47);
			end else if (trip.data >= 7'h20) begin
				res_d.kind       = ttx_pkg::KIND_G0;
				res_d.char_index = trip.data - 7'h20;
			end
		end
		if (res_d.kind != ttx_pkg::KIND_NONE)
			res_d.column = trip.addr;
		res_d.row = row_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				row_q       <= row_nxt;
				stop_q      <= stop_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= res_d;
	end

endmodule

`default_nettype wire

@@ rtl/teletext_enhancement_triplet_decoder_top.sv @@
// Teletext enhancement triplet decoder: one triplet in, one result out per
// transfer. The front end bit-reverses and Hamming 24/18 decodes the triplet in
// the accepting cycle and writes it to a four-entry queue; the back end applies
// row/termination state and classifies the replacement into an output register.
// Throughput is one triplet per clock when the output is taken every cycle; a
// result is registered at the output as its triplet is taken from the queue.
// Input and output stall independently, the queue absorbing up to four triplets
// plus one held result.
// Depends on ttx_pkg, ttx_front, ttx_queue, ttx_back.
`default_nettype none

module teletext_enhancement_triplet_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // byte_first[7:0], byte_second[15:8], byte_third[23:16]
	input  wire logic        s_tuser,  // packet_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // row[4:0], column[10:5], char_index[17:11],
	                                   // accent_index[21:18], letter_index[27:22], zero[31:28]
	output logic [4:0]       m_tuser   // kind[2:0], uncorrectable[3], terminated[4]
);

	ttx_pkg::trip_t trip_in, trip_head;
	ttx_pkg::res_t  res;
	logic           q_full, q_nonempty, q_pop;

	ttx_front u_front (
		.raw          (s_tdata),
		.packet_start (s_tuser),
		.trip         (trip_in)
	);

	assign s_tready = !q_full;

	ttx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && !q_full),
		.push_data (trip_in),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (trip_head)
	);

	ttx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_nonempty),
		.trip      (trip_head),
		.take      (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {4'd0, res.letter_index, res.accent_index, res.char_index,
		res.column, res.row};
	assign m_tuser = {res.terminated, res.uncorrectable, res.kind};

endmodule

`default_nettype wire

@@ rtl/ttx_checker.sv @@
// Port-level checks for the triplet decoder, bound to the top level.
// Depends on ttx_pkg and the assertion macros header.
`default_nettype none

`include "teletext_enhancement_triplet_decoder_top_macros.svh"

module ttx_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic [4:0]  m_tuser
);

	logic [2:0] kind;
	logic [4:0] row;
	logic [5:0] column;
	logic       flagged;

	assign kind    = m_tuser[2:0];
	assign flagged = m_tuser[3] || m_tuser[4];
	assign row     = m_tdata[4:0];
	assign column  = m_tdata[10:5];

	`TTX_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`TTX_ASSERT_IMP(a_flag_no_kind, clk, arst_n, m_tvalid && flagged,
		kind == ttx_pkg::KIND_NONE)
	`TTX_ASSERT_IMP(a_none_no_col, clk, arst_n, m_tvalid && kind == ttx_pkg::KIND_NONE,
		column == 6'd0)
	`TTX_ASSERT_IMP(a_row_range, clk, arst_n, m_tvalid, row <= ttx_pkg::ROW_ZERO_MAP)

endmodule

bind teletext_enhancement_triplet_decoder_top ttx_checker u_ttx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
